// ----- hdl/dmtt_pkg.sv -----
// package for the delayed message timer table
// holds sizes and codes, and the command and status structs shared by dmtt_ctrl, dmtt_dp and the top level
package dmtt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int HANDLE_W    = 16;
  localparam int TIME_W      = 32;

  localparam logic OP_POST = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic STATUS_DISPATCHED = 1'b0;
  localparam logic STATUS_REJECTED   = 1'b1;

  typedef struct packed {
    logic post_write;
    logic reject;
    logic scan_start;
    logic scan_step;
    logic flush_push;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
    logic need_push;
    logic hold_valid;
    logic out_free;
  } status_t;

endpackage

// ----- hdl/dmtt_if.sv -----
// request and result channel interfaces of the timer table
// depends on dmtt_pkg for field widths
interface dmtt_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [dmtt_pkg::HANDLE_W-1:0] message_handle;
  logic [dmtt_pkg::TIME_W-1:0]   delay_time;
  logic [dmtt_pkg::TIME_W-1:0]   elapsed_time;

  modport source (output valid, output operation, output message_handle,
                  output delay_time, output elapsed_time, input ready);
  modport sink   (input valid, input operation, input message_handle,
                  input delay_time, input elapsed_time, output ready);
endinterface

interface dmtt_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmtt_pkg::HANDLE_W-1:0] out_handle;
  logic                          result_status;
  logic                          last_of_run;

  modport source (output valid, output out_handle, output result_status,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_handle, input result_status,
                  input last_of_run, output ready);
endinterface

// ----- hdl/dmtt_ctrl.sv -----
// controller state machine of the timer table
// drives dmtt_pkg::cmd_t to the datapath from its dmtt_pkg::status_t
module dmtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic              req_op_i,
  output logic              req_ready_o,
  input  dmtt_pkg::status_t stat_i,
  output dmtt_pkg::cmd_t    cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign req_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept      = req_valid_i && req_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_op_i == dmtt_pkg::OP_TICK) begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else if (stat_i.full) begin
            cmd_o.reject = 1'b1;
          end else begin
            cmd_o.post_write = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          state_d = ST_FLUSH;
        end else if (!stat_i.need_push || stat_i.out_free) begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.hold_valid) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush_push = 1'b1;
          cmd_o.finish     = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/dmtt_dp.sv -----
// datapath of the timer table: entry store, scan and compaction, result register
// depends on dmtt_pkg; commanded by dmtt_ctrl
module dmtt_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dmtt_pkg::cmd_t                cmd_i,
  output dmtt_pkg::status_t             stat_o,
  input  logic [dmtt_pkg::HANDLE_W-1:0] handle_i,
  input  logic [dmtt_pkg::TIME_W-1:0]   delay_i,
  input  logic [dmtt_pkg::TIME_W-1:0]   elapsed_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [dmtt_pkg::HANDLE_W-1:0] out_handle_o,
  output logic                          out_status_o,
  output logic                          out_last_o
);

  logic [dmtt_pkg::HANDLE_W-1:0] handles_q [dmtt_pkg::TABLE_DEPTH];
  logic [dmtt_pkg::TIME_W-1:0]   delays_q  [dmtt_pkg::TABLE_DEPTH];

  logic [dmtt_pkg::CNT_W-1:0]    count_q, idx_q, kept_q;
  logic                          hold_valid_q, out_valid_q;
  logic [dmtt_pkg::HANDLE_W-1:0] hold_handle_q, out_handle_q;
  logic                          out_status_q, out_last_q;
  logic [dmtt_pkg::TIME_W-1:0]   elapsed_q;

  logic [dmtt_pkg::IDX_W-1:0]    rd_idx;
  logic [dmtt_pkg::TIME_W-1:0]   cur_delay, new_delay;
  logic                          expired, out_free, out_load;

  assign rd_idx    = idx_q[dmtt_pkg::IDX_W-1:0];
  assign cur_delay = delays_q[rd_idx];
  assign new_delay = (cur_delay > elapsed_q) ? (cur_delay - elapsed_q) : '0;
  assign expired   = (new_delay == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = cmd_i.reject || cmd_i.flush_push ||
                     (cmd_i.scan_step && expired && hold_valid_q);

  always_comb begin
    stat_o.full       = (count_q == dmtt_pkg::CNT_W'(dmtt_pkg::TABLE_DEPTH));
    stat_o.scan_done  = (idx_q == count_q);
    stat_o.need_push  = expired && hold_valid_q;
    stat_o.hold_valid = hold_valid_q;
    stat_o.out_free   = out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      idx_q        <= '0;
      kept_q       <= '0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.post_write) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q        <= '0;
        kept_q       <= '0;
        hold_valid_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
        if (expired) begin
          hold_valid_q <= 1'b1;
        end else begin
          kept_q <= kept_q + 1'b1;
        end
      end
      if (cmd_i.finish) begin
        count_q      <= kept_q;
        hold_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.post_write) begin
      handles_q[count_q[dmtt_pkg::IDX_W-1:0]] <= handle_i;
      delays_q[count_q[dmtt_pkg::IDX_W-1:0]]  <= delay_i;
    end
    if (cmd_i.scan_step && !expired) begin
      handles_q[kept_q[dmtt_pkg::IDX_W-1:0]] <= handles_q[rd_idx];
      delays_q[kept_q[dmtt_pkg::IDX_W-1:0]]  <= new_delay;
    end
    if (cmd_i.scan_start) begin
      elapsed_q <= elapsed_i;
    end
    if (cmd_i.scan_step && expired) begin
      hold_handle_q <= handles_q[rd_idx];
    end
    if (cmd_i.reject) begin
      out_handle_q <= handle_i;
      out_status_q <= dmtt_pkg::STATUS_REJECTED;
      out_last_q   <= 1'b1;
    end else if (cmd_i.flush_push) begin
      out_handle_q <= hold_handle_q;
      out_status_q <= dmtt_pkg::STATUS_DISPATCHED;
      out_last_q   <= 1'b1;
    end else if (cmd_i.scan_step && expired && hold_valid_q) begin
      out_handle_q <= hold_handle_q;
      out_status_q <= dmtt_pkg::STATUS_DISPATCHED;
      out_last_q   <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_handle_o = out_handle_q;
  assign out_status_o = out_status_q;
  assign out_last_o   = out_last_q;

endmodule

// ----- hdl/delayed_message_timer_table.sv -----
// top level of the delayed message timer table: dmtt_ctrl and dmtt_dp
// a post writes its entry when accepted; a rejected post's result is registered
// a tick runs the accept cycle, then the single scan step once per entry, then
// ends the scan and flushes the last result, with stalls while the result
// register waits to be taken
// reset clears the entry count and all control; stored entries stay undefined
// depends on dmtt_pkg and dmtt_if
module delayed_message_timer_table (
  input  logic     clk_i,
  input  logic     rst_ni,
  dmtt_in_if.sink  req_i,
  dmtt_out_if.source res_o
);

  dmtt_pkg::cmd_t    cmd;
  dmtt_pkg::status_t stat;

  dmtt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dmtt_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .handle_i     (req_i.message_handle),
    .delay_i      (req_i.delay_time),
    .elapsed_i    (req_i.elapsed_time),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_handle_o (res_o.out_handle),
    .out_status_o (res_o.result_status),
    .out_last_o   (res_o.last_of_run)
  );

endmodule

// ----- tb/dmtt_dispatch_checker.sv -----
`timescale 1ns / 100ps
// checker for the delayed message timer table: watches both channels, keeps its
// own copy of the table and compares each dispatched or rejected result in order
// depends on dmtt_pkg and the dmtt_in_if / dmtt_out_if interfaces
module dmtt_dispatch_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dmtt_in_if  req_mon,
  dmtt_out_if res_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import dmtt_pkg::*;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                status;
    logic                last;
  } dispatch_t;

  logic [HANDLE_W-1:0] timer_handle [TABLE_DEPTH];
  logic [TIME_W-1:0]   timer_delay  [TABLE_DEPTH];
  int                  timer_count;
  dispatch_t           due_q [$];
  int                  fails = 0;

  task automatic advance_timers(input logic op, input logic [HANDLE_W-1:0] handle,
                                input logic [TIME_W-1:0] delay,
                                input logic [TIME_W-1:0] elapsed);
    int                kept;
    int                first;
    int                i;
    logic [TIME_W-1:0] left;
    dispatch_t         item;
    kept  = 0;
    first = due_q.size();
    if (op == OP_POST) begin
      if (timer_count < TABLE_DEPTH) begin
        timer_handle[timer_count] = handle;
        timer_delay[timer_count]  = delay;
        timer_count++;
      end else begin
        item = '{handle: handle, status: STATUS_REJECTED, last: 1'b1};
        due_q.push_back(item);
      end
    end else begin
      for (i = 0; i < timer_count; i++) begin
        left = (timer_delay[i] > elapsed) ? timer_delay[i] - elapsed : '0;
        if (left == '0) begin
          item = '{handle: timer_handle[i], status: STATUS_DISPATCHED, last: 1'b0};
          due_q.push_back(item);
        end else begin
          timer_handle[kept] = timer_handle[i];
          timer_delay[kept]  = left;
          kept++;
        end
      end
      timer_count = kept;
      if (due_q.size() > first) begin
        item      = due_q.pop_back();
        item.last = 1'b1;
        due_q.push_back(item);
      end
    end
  endtask

  task automatic check_dispatch(input logic [HANDLE_W-1:0] handle, input logic status,
                                input logic last);
    dispatch_t want;
    if (due_q.size() == 0) begin
      $error("unexpected result: out_handle %h result_status %0d", handle, status);
      fails++;
    end else begin
      want = due_q.pop_front();
      if (handle !== want.handle) begin
        $error("out_handle: expected %h, actual %h", want.handle, handle);
        fails++;
      end
      if (status !== want.status) begin
        $error("result_status: expected %0d, actual %0d", want.status, status);
        fails++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last);
        fails++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_count = 0;
      due_q.delete();
    end else begin
      if (res_mon.valid && res_mon.ready)
        check_dispatch(res_mon.out_handle, res_mon.result_status, res_mon.last_of_run);
      if (req_mon.valid && req_mon.ready)
        advance_timers(req_mon.operation, req_mon.message_handle, req_mon.delay_time,
                       req_mon.elapsed_time);
    end
    pending_o    = due_q.size();
    fail_count_o = fails;
  end

endmodule

// ----- tb/delayed_message_timer_table_tb.sv -----
`timescale 1ns / 100ps
// top of the timer table testbench: clock, reset, request stimulus, result stalls
// and the verdict; depends on dmtt_pkg, the dmtt interfaces, the block and
// dmtt_dispatch_checker
module delayed_message_timer_table_tb;
  import dmtt_pkg::*;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending_left;
  bit   send_quiet = 1'b0;
  bit   take_quiet = 1'b0;

  dmtt_in_if  req_if ();
  dmtt_out_if res_if ();

  delayed_message_timer_table DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  dmtt_dispatch_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_left)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(input logic op, input logic [HANDLE_W-1:0] handle,
                              input logic [TIME_W-1:0] delay,
                              input logic [TIME_W-1:0] elapsed);
    int gap;
    if ($urandom_range(0, 9) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= op;
    req_if.message_handle <= handle;
    req_if.delay_time     <= delay;
    req_if.elapsed_time   <= elapsed;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  // hold off until every expected result has been taken
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_left != 0) @(negedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] pick_delay();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return $urandom();
    return $urandom_range(1, 3 << 16);
  endfunction

  function automatic logic [TIME_W-1:0] pick_elapsed();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return $urandom();
    return $urandom_range(0, 2 << 16);
  endfunction

  initial begin
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int stall;
      @(negedge clk_i);
      if ($urandom_range(0, 49) == 0) take_quiet = !take_quiet;
      stall = take_quiet ? 0 : pick_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  initial begin
    int n;
    req_if.valid          = 1'b0;
    req_if.operation      = OP_POST;
    req_if.message_handle = '0;
    req_if.delay_time     = '0;
    req_if.elapsed_time   = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // tick on an empty table, then zero and largest delay
    send_request(OP_TICK, 16'h1234, 32'hDEAD_BEEF, $urandom());
    send_request(OP_POST, 16'h0000, 32'h0000_0000, $urandom());
    send_request(OP_POST, 16'hFFFF, 32'hFFFF_FFFF, $urandom());
    send_request(OP_TICK, HANDLE_W'($urandom()), $urandom(), 32'h0000_0000);
    send_request(OP_TICK, HANDLE_W'($urandom()), $urandom(), 32'hFFFF_FFFF);
    // fill the table, overflow it, then expire it in two runs
    for (n = 0; n < TABLE_DEPTH; n++)
      send_request(OP_POST, HANDLE_W'(16'h0100 + n * 16'h0F0F),
                   TIME_W'((n * 7) % 3 + 1) << 16, $urandom());
    send_request(OP_POST, 16'hA5A5, $urandom(), $urandom());
    send_request(OP_TICK, HANDLE_W'($urandom()), $urandom(), 32'h0001_0000);
    send_request(OP_TICK, HANDLE_W'($urandom()), $urandom(), 32'hFFFF_FFFF);
    drain_results();

    for (n = 0; n < 100; n++) begin
      if ($urandom_range(0, 19) == 0) drain_results();
      if ($urandom_range(0, 99) < 65)
        send_request(OP_POST, HANDLE_W'($urandom()), pick_delay(), $urandom());
      else
        send_request(OP_TICK, HANDLE_W'($urandom()), $urandom(), pick_elapsed());
    end
    drain_results();
    repeat (40) @(negedge clk_i);

    if (fail_count == 0)
      $display("delayed_message_timer_table regression: pass");
    else
      $display("delayed_message_timer_table regression: fail");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("delayed_message_timer_table regression: fail");
    $finish;
  end

endmodule
